// ===== rtl/qyfr_pkg.sv =====
// Package for the quaternion yaw frame rotation block: widths, CORDIC constants
// and the arctangent table. No dependencies.
`default_nettype none
package qyfr_pkg;
    localparam int CordicStepsDefault = 16;
    localparam int AngTableLen = 24;
    localparam int VecW = 40;  // vectoring datapath: |terms| < 2^35, gain growth < 2^2
    localparam int AngW = 34;  // Q2.30 angle plus headroom
    localparam int RotW = 34;  // rotation datapath, Q2.30 with headroom
    localparam logic signed [AngW-1:0] Q30HalfPi = 34'sd1686629713;
    localparam logic signed [AngW-1:0] Q30Pi = 34'sd3373259426;
    localparam logic signed [RotW-1:0] Q30Gain = 34'sd652032874;
    localparam logic signed [15:0] HeadLimit = 16'sd25736;
    localparam logic [0:0] RegRefX = 1'b0;
    localparam logic [0:0] RegRefY = 1'b1;

    function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0: atan_q30 = 34'sd843314857;
            5'd1: atan_q30 = 34'sd497837829;
            5'd2: atan_q30 = 34'sd263043837;
            5'd3: atan_q30 = 34'sd133525159;
            5'd4: atan_q30 = 34'sd67021687;
            5'd5: atan_q30 = 34'sd33543516;
            5'd6: atan_q30 = 34'sd16775851;
            5'd7: atan_q30 = 34'sd8388437;
            5'd8: atan_q30 = 34'sd4194283;
            5'd9: atan_q30 = 34'sd2097149;
            default: atan_q30 = (i < 5'd24) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/quaternion_yaw_frame_rotation.sv =====
// Top level of the quaternion yaw frame rotation block: term products, vectoring
// and rotation CORDIC pipelines, output multiply and rounding. Uses qyfr_pkg.
// Throughput is one sample per clock. Between the start beat and the o_valid strobe
// the pipeline holds one register per CORDIC iteration in each of the two CORDIC
// chains, with CORDIC_STEPS capped at 24. The six other stages are the term
// products, num and den, the range fold, the reference products, the rounding and
// the output register.
// The receiver cannot stall the block: each result is presented for exactly one
// cycle on o_valid, and busy is never raised.
`default_nettype none
module quaternion_yaw_frame_rotation #(
    parameter int CORDIC_STEPS = qyfr_pkg::CordicStepsDefault
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire signed [15:0] i_quat_x,
    input  wire signed [15:0] i_quat_y,
    input  wire signed [15:0] i_quat_z,
    input  wire signed [15:0] i_quat_w,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire        [0:0]  i_cfg_index,
    input  wire        [31:0] i_cfg_data,
    output logic              o_valid,
    output logic signed [31:0] o_forward_setpoint,
    output logic signed [31:0] o_lateral_setpoint,
    output logic signed [15:0] o_heading_angle
);
    localparam int N = (CORDIC_STEPS > qyfr_pkg::AngTableLen) ? qyfr_pkg::AngTableLen
                                                              : CORDIC_STEPS;
    localparam int VW = qyfr_pkg::VecW;
    localparam int AW = qyfr_pkg::AngW;
    localparam int RW = qyfr_pkg::RotW;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic signed [31:0] r_ref_x, r_ref_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == qyfr_pkg::RegRefX) r_ref_x <= i_cfg_data;
            else r_ref_y <= i_cfg_data;
        end
    end

    // Stage 1: the six squares and products.
    logic               r_v1;
    logic signed [31:0] r_pwz, r_pxy, r_pww, r_pxx, r_pyy, r_pzz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= start;
        r_pwz <= i_quat_w * i_quat_z;
        r_pxy <= i_quat_x * i_quat_y;
        r_pww <= i_quat_w * i_quat_w;
        r_pxx <= i_quat_x * i_quat_x;
        r_pyy <= i_quat_y * i_quat_y;
        r_pzz <= i_quat_z * i_quat_z;
    end

    // Stage 2: num, den and the quarter-turn prerotation for the left half plane.
    logic               r_v2;
    logic signed [VW-1:0] r_vx0, r_vy0;
    logic signed [AW-1:0] r_vz0;
    logic signed [VW-1:0] n_num, n_den;
    always_comb begin
        n_num = (VW'(r_pwz) + VW'(r_pxy)) <<< 1;
        n_den = VW'(r_pww) + VW'(r_pxx) - VW'(r_pyy) - VW'(r_pzz);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= r_v1;
        if (n_den < 0) begin
            if (n_num >= 0) begin
                r_vx0 <= n_num; r_vy0 <= -n_den; r_vz0 <= qyfr_pkg::Q30HalfPi;
            end else begin
                r_vx0 <= -n_num; r_vy0 <= n_den; r_vz0 <= -qyfr_pkg::Q30HalfPi;
            end
        end else begin
            r_vx0 <= n_den; r_vy0 <= n_num; r_vz0 <= '0;
        end
    end

    // Vectoring chain: one register stage per iteration. A zero vector stays at
    // angle zero since its flag bypasses the direction decisions.
    logic                 r_vv [0:N];
    logic                 r_vzero [0:N];
    logic signed [VW-1:0] r_vx [0:N];
    logic signed [VW-1:0] r_vy [0:N];
    logic signed [AW-1:0] r_vz [0:N];
    always_comb begin
        r_vv[0] = r_v2;
        r_vzero[0] = (r_vx0 == 0) && (r_vy0 == 0);
        r_vx[0] = r_vx0;
        r_vy[0] = r_vy0;
        r_vz[0] = r_vz0;
    end
    for (genvar g = 0; g < N; g++) begin : g_vec
        logic signed [AW-1:0] w_atan;
        assign w_atan = qyfr_pkg::atan_q30(5'(g));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vv[g+1] <= 1'b0;
            else r_vv[g+1] <= r_vv[g];
            r_vzero[g+1] <= r_vzero[g];
            if (r_vzero[g]) begin
                r_vx[g+1] <= r_vx[g]; r_vy[g+1] <= r_vy[g]; r_vz[g+1] <= r_vz[g];
            end else if (r_vy[g] >= 0) begin
                r_vx[g+1] <= r_vx[g] + (r_vy[g] >>> g);
                r_vy[g+1] <= r_vy[g] - (r_vx[g] >>> g);
                r_vz[g+1] <= r_vz[g] + w_atan;
            end else begin
                r_vx[g+1] <= r_vx[g] - (r_vy[g] >>> g);
                r_vy[g+1] <= r_vy[g] + (r_vx[g] >>> g);
                r_vz[g+1] <= r_vz[g] - w_atan;
            end
        end
    end

    // Range fold into the right half plane before the rotation chain.
    logic                 r_v3, r_flip3;
    logic signed [AW-1:0] r_ang3, r_rz0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else r_v3 <= r_vv[N];
        r_ang3 <= r_vz[N];
        if (r_vz[N] > qyfr_pkg::Q30HalfPi) begin
            r_rz0 <= r_vz[N] - qyfr_pkg::Q30Pi; r_flip3 <= 1'b1;
        end else if (r_vz[N] < -qyfr_pkg::Q30HalfPi) begin
            r_rz0 <= r_vz[N] + qyfr_pkg::Q30Pi; r_flip3 <= 1'b1;
        end else begin
            r_rz0 <= r_vz[N]; r_flip3 <= 1'b0;
        end
    end

    logic                 r_rv [0:N];
    logic                 r_rflip [0:N];
    logic signed [AW-1:0] r_rang [0:N];
    logic signed [RW-1:0] r_rx [0:N];
    logic signed [RW-1:0] r_ry [0:N];
    logic signed [AW-1:0] r_rz [0:N];
    always_comb begin
        r_rv[0] = r_v3;
        r_rflip[0] = r_flip3;
        r_rang[0] = r_ang3;
        r_rx[0] = qyfr_pkg::Q30Gain;
        r_ry[0] = '0;
        r_rz[0] = r_rz0;
    end
    for (genvar g = 0; g < N; g++) begin : g_rot
        logic signed [AW-1:0] w_atan;
        assign w_atan = qyfr_pkg::atan_q30(5'(g));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_rv[g+1] <= 1'b0;
            else r_rv[g+1] <= r_rv[g];
            r_rflip[g+1] <= r_rflip[g];
            r_rang[g+1] <= r_rang[g];
            if (r_rz[g] >= 0) begin
                r_rx[g+1] <= r_rx[g] - (r_ry[g] >>> g);
                r_ry[g+1] <= r_ry[g] + (r_rx[g] >>> g);
                r_rz[g+1] <= r_rz[g] - w_atan;
            end else begin
                r_rx[g+1] <= r_rx[g] + (r_ry[g] >>> g);
                r_ry[g+1] <= r_ry[g] - (r_rx[g] >>> g);
                r_rz[g+1] <= r_rz[g] + w_atan;
            end
        end
    end

    // Four products of the reference point with cos and sin, then sums.
    logic                 r_v4, r_v5;
    logic signed [RW-1:0] n_cos, n_sin;
    logic signed [65:0]   r_xc, r_ys, r_yc, r_xs;
    logic signed [AW-1:0] r_ang4;
    logic signed [15:0]   r_head5;
    logic signed [67:0]   r_fwd5, r_lat5;
    logic signed [AW-1:0] n_hr;
    always_comb begin
        n_cos = r_rflip[N] ? -r_rx[N] : r_rx[N];
        n_sin = r_rflip[N] ? -r_ry[N] : r_ry[N];
        n_hr = (r_ang4 + (AW'(1) <<< 16)) >>> 17;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else begin
            r_v4 <= r_rv[N]; r_v5 <= r_v4;
        end
        r_xc <= r_ref_x * n_cos;
        r_ys <= r_ref_y * n_sin;
        r_yc <= r_ref_y * n_cos;
        r_xs <= r_ref_x * n_sin;
        r_ang4 <= r_rang[N];
        r_fwd5 <= ((68'(r_xc) + 68'(r_ys)) + (68'sd1 <<< 29)) >>> 30;
        r_lat5 <= ((68'(r_yc) - 68'(r_xs)) + (68'sd1 <<< 29)) >>> 30;
        if (n_hr > AW'(qyfr_pkg::HeadLimit)) r_head5 <= qyfr_pkg::HeadLimit;
        else if (n_hr < -AW'(qyfr_pkg::HeadLimit)) r_head5 <= -qyfr_pkg::HeadLimit;
        else r_head5 <= 16'(n_hr);
    end

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) sat32 = 32'sh7fffffff;
        else if (v < -68'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = 32'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r_v5;
        o_forward_setpoint <= sat32(r_fwd5);
        o_lateral_setpoint <= sat32(r_lat5);
        o_heading_angle <= r_head5;
    end

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading_angle <= qyfr_pkg::HeadLimit &&
                     o_heading_angle >= -qyfr_pkg::HeadLimit))
        else $error("heading out of range");
    a_valid_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |=> o_valid) else $error("result beat lost");
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_rz0 <= qyfr_pkg::Q30HalfPi && r_rz0 >= -qyfr_pkg::Q30HalfPi))
        else $error("rotation angle not folded");
endmodule
`default_nettype wire
